// ----- src/assert_macros.svh -----
// Assertion macros used by the translator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- src/mtx_pkg.sv -----
// Shared types and constants for the MIPS to x86-64 ALU translator.
`timescale 1ns / 1ps

package mtx_pkg;

  localparam int MAX_BYTES = 21;
  localparam int SEQ_W = MAX_BYTES * 8;
  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  localparam logic CFG_HI = 1'b0;
  localparam logic CFG_LO = 1'b1;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI = 6'h0C;
  localparam logic [5:0] OP_ORI = 6'h0D;
  localparam logic [5:0] OP_XORI = 6'h0E;
  localparam logic [5:0] OP_LUI = 6'h0F;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRL = 6'h02;
  localparam logic [5:0] FN_SRA = 6'h03;
  localparam logic [5:0] FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06;
  localparam logic [5:0] FN_SRAV = 6'h07;
  localparam logic [5:0] FN_MOVZ = 6'h0A;
  localparam logic [5:0] FN_MOVN = 6'h0B;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MTHI = 6'h11;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MTLO = 6'h13;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR = 6'h25;
  localparam logic [5:0] FN_XOR = 6'h26;
  localparam logic [5:0] FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [CNT_W-1:0] count;
    logic has_bytes;
    logic compiled;
  } gen_t;

endpackage

// ----- src/mips_to_x86_alu_translator.sv -----
// Top level of the MIPS to x86-64 ALU translator.
`timescale 1ns / 1ps

// Translates one MIPS32 instruction item into x86-64 code, sent one byte per
// cycle on the result ports while result_strobe is high, with last marking the
// final byte. An instruction gives from 1 to 21 bytes; the next item is taken
// while the final byte of the current one goes out, so items follow each other
// with no gap. An accepted item waits in the input register until the shifter
// is ready, and its bytes then pass through the shifter and the result register.
// An instruction that is not translated, or one that emits no code, gives a
// single result with byte_valid low. The receiver cannot stall.
// The displacement registers should be written only while the block is idle.

`include "assert_macros.svh"

module mips_to_x86_alu_translator import mtx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] instr_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_strobe,
  output logic [7:0]  code_byte,
  output logic        byte_valid,
  output logic        compiled,
  output logic        last
);

  logic in_valid;
  logic in_valid_next;
  logic [31:0] in_word;
  logic [15:0] hi_disp;
  logic [15:0] lo_disp;
  logic emit_ready;
  logic load;
  logic accept;
  gen_t gen;

  assign load = in_valid && emit_ready;
  assign busy = in_valid && !emit_ready;
  assign accept = start && !busy;

  always_comb begin
    in_valid_next = in_valid;
    if (accept) begin
      in_valid_next = 1'b1;
    end else if (load) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      hi_disp <= 16'd128;
      lo_disp <= 16'd132;
    end else begin
      in_valid <= in_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_HI: hi_disp <= cfg_data;
          CFG_LO: lo_disp <= cfg_data;
          default: ;
        endcase
      end
    end
    if (accept) begin
      in_word <= instr_word;
    end
  end

  mtx_gen u_gen (
    .word    (in_word),
    .hi_disp (hi_disp),
    .lo_disp (lo_disp),
    .gen     (gen)
  );

  mtx_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .gen           (gen),
    .ready         (emit_ready),
    .result_strobe (result_strobe),
    .code_byte     (code_byte),
    .byte_valid    (byte_valid),
    .compiled      (compiled),
    .last          (last)
  );

  `ASSERT_NEXT(a_load_gives_result, clk, rst, load, ##1 result_strobe)
  `ASSERT_NEXT(a_busy_holds_item, clk, rst, busy, in_valid)
  `ASSERT_IMPL(a_empty_is_single, clk, rst, result_strobe && !byte_valid, last)
  `ASSERT_IMPL(a_uncompiled_empty, clk, rst, result_strobe && !compiled, !byte_valid)

endmodule

// ----- src/mtx_gen.sv -----
// Decoder that builds the full x86-64 byte sequence for one MIPS instruction.
`timescale 1ns / 1ps

module mtx_gen import mtx_pkg::*; (
  input  logic [31:0] word,
  input  logic [15:0] hi_disp,
  input  logic [15:0] lo_disp,
  output gen_t        gen
);

  logic [5:0] opc;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [4:0] rd;
  logic [4:0] sh;
  logic [5:0] fn;
  logic [15:0] imm;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic rd_live;
  logic rt_live;
  logic [SEQ_W-1:0] seq;
  logic [CNT_W-1:0] nb;
  logic ok;

  assign opc = word[31:26];
  assign rs = word[25:21];
  assign rt = word[20:16];
  assign rd = word[15:11];
  assign sh = word[10:6];
  assign fn = word[5:0];
  assign imm = word[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'h0000, imm};
  assign rd_live = (rd != 5'd0);
  assign rt_live = (rt != 5'd0);

  function automatic logic [31:0] le32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [31:0] ld_reg(input logic [1:0] x, input logic [4:0] n);
    return {8'h41, 8'h8B, 2'b01, 1'b0, x, 3'b111, 1'b0, n, 2'b00};
  endfunction

  function automatic logic [31:0] st_reg(input logic [4:0] n);
    return {8'h41, 8'h89, 8'h47, 1'b0, n, 2'b00};
  endfunction

  function automatic logic [31:0] alu_mem(input logic [7:0] op, input logic [4:0] n);
    return {8'h41, op, 8'h47, 1'b0, n, 2'b00};
  endfunction

  function automatic logic [55:0] ld_disp(input logic [15:0] d);
    return {8'h41, 8'h8B, 8'h87, le32({16'h0000, d})};
  endfunction

  function automatic logic [55:0] st_disp(input logic [15:0] d);
    return {8'h41, 8'h89, 8'h87, le32({16'h0000, d})};
  endfunction

  function automatic logic [47:0] flag_eax(input logic [7:0] cc);
    return {8'h0F, cc, 8'hC0, 8'h0F, 8'hB6, 8'hC0};
  endfunction

  // The register store sits at the end of every sequence that has one, so dropping it
  // for register zero only shortens the byte count.
  always_comb begin
    seq = '0;
    nb = '0;
    ok = 1'b1;
    case (opc)
      OP_RTYPE: begin
        case (fn)
          FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_XOR: begin
            case (fn)
              FN_ADDU: seq[SEQ_W-1 -: 96] = {ld_reg(2'd0, rs), alu_mem(8'h03, rt), st_reg(rd)};
              FN_SUBU: seq[SEQ_W-1 -: 96] = {ld_reg(2'd0, rs), alu_mem(8'h2B, rt), st_reg(rd)};
              FN_AND: seq[SEQ_W-1 -: 96] = {ld_reg(2'd0, rs), alu_mem(8'h23, rt), st_reg(rd)};
              FN_OR: seq[SEQ_W-1 -: 96] = {ld_reg(2'd0, rs), alu_mem(8'h0B, rt), st_reg(rd)};
              default: seq[SEQ_W-1 -: 96] = {ld_reg(2'd0, rs), alu_mem(8'h33, rt), st_reg(rd)};
            endcase
            nb = rd_live ? CNT_W'(12) : CNT_W'(8);
          end
          FN_NOR: begin
            seq[SEQ_W-1 -: 112] = {ld_reg(2'd0, rs), alu_mem(8'h0B, rt), 8'hF7, 8'hD0,
                                   st_reg(rd)};
            nb = rd_live ? CNT_W'(14) : CNT_W'(10);
          end
          FN_SLT, FN_SLTU: begin
            seq[SEQ_W-1 -: 144] = {ld_reg(2'd0, rs), alu_mem(8'h3B, rt),
                                   flag_eax((fn == FN_SLT) ? 8'h9C : 8'h92), st_reg(rd)};
            nb = rd_live ? CNT_W'(18) : CNT_W'(14);
          end
          FN_SLL, FN_SRL, FN_SRA: begin
            seq[SEQ_W-1 -: 88] = {ld_reg(2'd0, rt), 8'hC1,
                                  (fn == FN_SLL) ? 8'hE0 : ((fn == FN_SRL) ? 8'hE8 : 8'hF8),
                                  3'b000, sh, st_reg(rd)};
            nb = rd_live ? CNT_W'(11) : CNT_W'(7);
          end
          FN_SLLV, FN_SRLV, FN_SRAV: begin
            seq[SEQ_W-1 -: 112] = {ld_reg(2'd0, rt), ld_reg(2'd1, rs), 8'hD3,
                                   (fn == FN_SLLV) ? 8'hE0 :
                                   ((fn == FN_SRLV) ? 8'hE8 : 8'hF8),
                                   st_reg(rd)};
            nb = rd_live ? CNT_W'(14) : CNT_W'(10);
          end
          FN_MFHI, FN_MFLO: begin
            seq[SEQ_W-1 -: 88] = {ld_disp((fn == FN_MFHI) ? hi_disp : lo_disp), st_reg(rd)};
            nb = rd_live ? CNT_W'(11) : CNT_W'(7);
          end
          FN_MTHI, FN_MTLO: begin
            seq[SEQ_W-1 -: 88] = {ld_reg(2'd0, rs),
                                  st_disp((fn == FN_MTHI) ? hi_disp : lo_disp)};
            nb = CNT_W'(11);
          end
          FN_MOVZ, FN_MOVN: begin
            seq = {ld_reg(2'd0, rd), ld_reg(2'd2, rs), ld_reg(2'd1, rt), 8'h85, 8'hC9,
                   8'h0F, (fn == FN_MOVZ) ? 8'h44 : 8'h45, 8'hC2, st_reg(rd)};
            nb = rd_live ? CNT_W'(21) : CNT_W'(17);
          end
          default: begin
            ok = 1'b0;
          end
        endcase
      end
      OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI: begin
        case (opc)
          OP_ADDIU: seq[SEQ_W-1 -: 104] = {ld_reg(2'd0, rs), 8'h05, le32(simm), st_reg(rt)};
          OP_ANDI: seq[SEQ_W-1 -: 104] = {ld_reg(2'd0, rs), 8'h25, le32(zimm), st_reg(rt)};
          OP_ORI: seq[SEQ_W-1 -: 104] = {ld_reg(2'd0, rs), 8'h0D, le32(zimm), st_reg(rt)};
          default: seq[SEQ_W-1 -: 104] = {ld_reg(2'd0, rs), 8'h35, le32(zimm), st_reg(rt)};
        endcase
        nb = rt_live ? CNT_W'(13) : CNT_W'(9);
      end
      OP_SLTI, OP_SLTIU: begin
        seq[SEQ_W-1 -: 152] = {ld_reg(2'd0, rs), 8'h3D, le32(simm),
                               flag_eax((opc == OP_SLTI) ? 8'h9C : 8'h92), st_reg(rt)};
        nb = rt_live ? CNT_W'(19) : CNT_W'(15);
      end
      OP_LUI: begin
        if (rt_live) begin
          seq[SEQ_W-1 -: 64] = {8'h41, 8'hC7, 8'h47, 1'b0, rt, 2'b00, le32({imm, 16'h0000})};
          nb = CNT_W'(8);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    gen.seq = seq;
    gen.count = (nb == '0) ? CNT_W'(1) : nb;
    gen.has_bytes = (nb != '0);
    gen.compiled = ok;
  end

endmodule

// ----- src/mtx_emit.sv -----
// Byte shifter and result register that send one code byte per cycle.
`timescale 1ns / 1ps

module mtx_emit import mtx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  gen_t       gen,
  output logic       ready,
  output logic       result_strobe,
  output logic [7:0] code_byte,
  output logic       byte_valid,
  output logic       compiled,
  output logic       last
);

  logic [SEQ_W-1:0] seq;
  logic [CNT_W-1:0] cnt;
  logic has_bytes;
  logic ok;

  // The buffer can take the next item while its final byte goes out.
  assign ready = (cnt[CNT_W-1:1] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      result_strobe <= 1'b0;
    end else begin
      if (load) begin
        seq <= gen.seq;
        cnt <= gen.count;
        has_bytes <= gen.has_bytes;
        ok <= gen.compiled;
      end else if (cnt != '0) begin
        seq <= {seq[SEQ_W-9:0], 8'h00};
        cnt <= cnt - CNT_W'(1);
      end
      result_strobe <= (cnt != '0);
    end
    code_byte <= seq[SEQ_W-1 -: 8];
    byte_valid <= has_bytes;
    compiled <= ok;
    last <= (cnt == CNT_W'(1));
  end

endmodule
